>>> rtl/cfpp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfpp_pkg
// Shared types and constants for the CRC-16 framed packet parser.
// ----------------------------------------------------------------------------
package cfpp_pkg;

	// Frame markers and CRC-16/MODBUS constants
	localparam logic [7:0]  HDR_BYTE  = 8'hAA;
	localparam logic [7:0]  TAIL_BYTE = 8'h55;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'hA001;

	// Payload limits and decode layout
	localparam int unsigned PAYLOAD_LIMIT_DEF = 64;
	localparam int unsigned DECODE_DEPTH      = 10;
	localparam int unsigned ENV_MIN_LEN       = 4;
	localparam int unsigned SEQ_MIN_LEN       = 10;
	localparam int unsigned TEMP_SCALE        = 10;

	// Register reset values
	localparam logic [6:0] MAX_LEN_RST  = 7'd64;
	localparam logic [7:0] ENV_TYPE_RST = 8'h01;

	// Register indexes on the write port
	typedef enum logic {
		REG_MAX_LEN  = 1'b0,
		REG_ENV_TYPE = 1'b1
	} cfpp_reg_t;

	typedef enum logic [2:0] {
		ST_ENV      = 3'd0,
		ST_OTHER    = 3'd1,
		ST_CRC_ERR  = 3'd2,
		ST_TAIL_ERR = 3'd3,
		ST_TOO_LONG = 3'd4
	} cfpp_status_t;

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_TYPE   = 3'd1,
		PH_LEN    = 3'd2,
		PH_DATA   = 3'd3,
		PH_CRCLO  = 3'd4,
		PH_CRCHI  = 3'd5,
		PH_TAIL   = 3'd6
	} cfpp_phase_t;

	// First payload bytes kept for the environment record
	typedef logic [DECODE_DEPTH-1:0][7:0] cfpp_dbytes_t;

	// Frame status as produced by the parser
	typedef struct packed {
		cfpp_status_t status;
		logic [7:0]   frame_type;
		logic [7:0]   payload_length;
	} cfpp_hdr_t;

	// Decoded environment record
	typedef struct packed {
		logic [7:0]  floor_number;
		logic [11:0] temperature_tenths;
		logic [7:0]  humidity;
		logic        has_sequence;
		logic [15:0] sequence_number;
		logic [31:0] device_time_ms;
	} cfpp_env_t;

endpackage

>>> rtl/crc16_framed_packet_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc16_framed_packet_parser_unit
// Byte stream parser for AA/type/len/payload/crc16/55 frames; one status item
// per finished or dropped frame, with environment record decode.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                         tuser
//  s_*       in   data_byte[7:0]                -
//  m_*       out  type/len/floor/temp/hum/seq/t {has_sequence, status}
//  cfg_*     in   write port, index 0 max_payload_length, 1 env_frame_type
//
//  One byte per cycle sustained while the output drains. An accepted byte sits
//  in the input stage, the parser FSM and decode run in one pass, and status
//  items land in the output register.
//  Reset (arst_n low) puts the parser in header hunt with the CRC at 0xFFFF.
//  A stalled output holds its item; one more byte is taken into the input
//  stage, after which s_tready drops until the output drains.
// ----------------------------------------------------------------------------
module crc16_framed_packet_parser_unit #(
	parameter int unsigned PAYLOAD_LIMIT = cfpp_pkg::PAYLOAD_LIMIT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input bytes
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	// status items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // [7:0] frame_type, [15:8] payload_length,
	                               // [23:16] floor_number, [35:24] temperature_tenths,
	                               // [43:36] humidity, [59:44] sequence_number,
	                               // [91:60] device_time_ms, [95:92] zero
	output logic [3:0]  m_tuser,   // [2:0] status, [3] has_sequence
	// configuration
	input  logic        cfg_wr_en,
	input  logic        cfg_addr,
	input  logic [7:0]  cfg_wdata
);
	import cfpp_pkg::*;

	// Configuration registers
	logic [6:0] max_len_q;
	logic [7:0] env_type_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q  <= MAX_LEN_RST;
			env_type_q <= ENV_TYPE_RST;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				REG_MAX_LEN:  max_len_q  <= cfg_wdata[6:0];
				REG_ENV_TYPE: env_type_q <= cfg_wdata;
				default:      ;
			endcase
		end
	end

	// Input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       valid_s2;

	// The input stage moves on whenever the output register is free or draining
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			byte_s1 <= s_tdata;
	end

	// Parser and decode
	logic         res_valid;
	cfpp_hdr_t    res_hdr;
	cfpp_dbytes_t dbytes;
	cfpp_env_t    res_env;

	cfpp_parser #(
		.PAYLOAD_LIMIT (PAYLOAD_LIMIT)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.data_byte (byte_s1),
		.max_len   (max_len_q),
		.env_type  (env_type_q),
		.res_valid (res_valid),
		.res       (res_hdr),
		.dbytes    (dbytes)
	);

	cfpp_decode u_decode (
		.hdr    (res_hdr),
		.dbytes (dbytes),
		.env    (res_env)
	);

	// Output register
	cfpp_hdr_t hdr_s2;
	cfpp_env_t env_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (advance)
			valid_s2 <= res_valid;
		else if (m_tready)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			hdr_s2 <= res_hdr;
			env_s2 <= res_env;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'd0, env_s2.device_time_ms, env_s2.sequence_number, env_s2.humidity,
	                   env_s2.temperature_tenths, env_s2.floor_number,
	                   hdr_s2.payload_length, hdr_s2.frame_type};
	assign m_tuser  = {env_s2.has_sequence, hdr_s2.status};

	// Checks
	a_new_item_from_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(advance))
		else $error("status item appeared without a parser step");

	a_seq_only_env: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && env_s2.has_sequence |-> hdr_s2.status == ST_ENV)
		else $error("has_sequence set on a non-environment status");

	a_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && hdr_s2.status != ST_ENV |->
			env_s2.floor_number == 8'd0 && env_s2.temperature_tenths == 12'd0 &&
			env_s2.humidity == 8'd0 && env_s2.device_time_ms == 32'd0)
		else $error("decoded fields nonzero on a non-environment status");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1))
		else $error("input stage lost a byte while stalled");

endmodule

>>> rtl/cfpp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfpp_parser
// Frame state machine: header hunt, CRC accumulation, payload capture, status.
// ----------------------------------------------------------------------------
module cfpp_parser #(
	parameter int unsigned PAYLOAD_LIMIT = cfpp_pkg::PAYLOAD_LIMIT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           data_byte,
	input  logic [6:0]           max_len,
	input  logic [7:0]           env_type,
	output logic                 res_valid,
	output cfpp_pkg::cfpp_hdr_t  res,
	output cfpp_pkg::cfpp_dbytes_t dbytes
);
	import cfpp_pkg::*;

	localparam logic [7:0] LIMIT = 8'(PAYLOAD_LIMIT);

	// One byte of CRC-16/MODBUS, LSB first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	cfpp_phase_t phase_q, phase_d;
	logic [15:0] crc_q;
	logic [7:0]  type_q;
	logic [6:0]  len_q;
	logic [6:0]  pos_q;
	logic [7:0]  crc_lo_q;
	cfpp_dbytes_t dbytes_q;

	logic [15:0] crc_next;
	logic [7:0]  limit;
	logic        too_long;
	logic [6:0]  pos_inc;

	assign crc_next = crc_byte(crc_q, data_byte);
	assign limit    = ({1'b0, max_len} > LIMIT) ? LIMIT : {1'b0, max_len};
	assign too_long = data_byte > limit;
	assign pos_inc  = pos_q + 7'd1;

	// Next phase
	always_comb begin
		phase_d = PH_HEADER;
		case (phase_q)
			PH_TYPE:  phase_d = PH_LEN;
			PH_LEN: begin
				if (too_long)
					phase_d = PH_HEADER;
				else if (data_byte != 8'd0)
					phase_d = PH_DATA;
				else
					phase_d = PH_CRCLO;
			end
			PH_DATA:  phase_d = (pos_inc >= len_q) ? PH_CRCLO : PH_DATA;
			PH_CRCLO: phase_d = PH_CRCHI;
			PH_CRCHI: phase_d = ({data_byte, crc_lo_q} == crc_q) ? PH_TAIL : PH_HEADER;
			PH_TAIL:  phase_d = PH_HEADER;
			default:  phase_d = (data_byte == HDR_BYTE) ? PH_TYPE : PH_HEADER;
		endcase
	end

	// Status output
	always_comb begin
		res_valid          = 1'b0;
		res.status         = ST_OTHER;
		res.frame_type     = type_q;
		res.payload_length = {1'b0, len_q};
		case (phase_q)
			PH_LEN: begin
				if (too_long) begin
					res_valid          = 1'b1;
					res.status         = ST_TOO_LONG;
					res.payload_length = data_byte;
				end
			end
			PH_CRCHI: begin
				if ({data_byte, crc_lo_q} != crc_q) begin
					res_valid  = 1'b1;
					res.status = ST_CRC_ERR;
				end
			end
			PH_TAIL: begin
				res_valid = 1'b1;
				if (data_byte != TAIL_BYTE)
					res.status = ST_TAIL_ERR;
				else if (type_q == env_type && len_q >= 7'(ENV_MIN_LEN))
					res.status = ST_ENV;
				else
					res.status = ST_OTHER;
			end
			default: res_valid = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			crc_q    <= CRC_INIT;
			type_q   <= 8'd0;
			len_q    <= 7'd0;
			pos_q    <= 7'd0;
			crc_lo_q <= 8'd0;
		end else if (step) begin
			phase_q <= phase_d;
			case (phase_q)
				PH_TYPE: begin
					type_q <= data_byte;
					crc_q  <= crc_next;
				end
				PH_LEN: begin
					crc_q <= crc_next;
					if (!too_long) begin
						len_q <= data_byte[6:0];
						pos_q <= 7'd0;
					end
				end
				PH_DATA: begin
					crc_q <= crc_next;
					pos_q <= pos_inc;
				end
				PH_CRCLO: crc_lo_q <= data_byte;
				PH_CRCHI, PH_TAIL: ;
				default: begin
					if (data_byte == HDR_BYTE)
						crc_q <= CRC_INIT;
				end
			endcase
		end
	end

	// Payload capture, first bytes only
	always_ff @(posedge clk) begin
		if (step && phase_q == PH_DATA && pos_q < 7'(DECODE_DEPTH))
			dbytes_q[pos_q[3:0]] <= data_byte;
	end

	assign dbytes = dbytes_q;

endmodule

>>> rtl/cfpp_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfpp_decode
// Environment record decode from the captured payload bytes.
// ----------------------------------------------------------------------------
module cfpp_decode (
	input  cfpp_pkg::cfpp_hdr_t    hdr,
	input  cfpp_pkg::cfpp_dbytes_t dbytes,
	output cfpp_pkg::cfpp_env_t    env
);
	import cfpp_pkg::*;

	logic is_env;
	logic seq_ok;

	assign is_env = hdr.status == ST_ENV;
	assign seq_ok = is_env && (hdr.payload_length >= 8'(SEQ_MIN_LEN));

	always_comb begin
		env.floor_number       = is_env ? dbytes[0] : 8'd0;
		env.temperature_tenths = is_env
			? (12'(dbytes[1]) * 12'(TEMP_SCALE) + 12'(dbytes[2])) : 12'd0;
		env.humidity           = is_env ? dbytes[3] : 8'd0;
		env.has_sequence       = seq_ok;
		env.sequence_number    = seq_ok ? {dbytes[5], dbytes[4]} : 16'd0;
		env.device_time_ms     = seq_ok ? {dbytes[9], dbytes[8], dbytes[7], dbytes[6]} : 32'd0;
	end

endmodule

>>> tb/sv/cfpp_status_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfpp_status_checker
// Watches the byte, status and register channels of the frame parser, tracks
// the parser state from the accepted bytes and compares every status item
// field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module cfpp_status_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [95:0] m_tdata,
	input  logic [3:0]  m_tuser,
	input  logic        cfg_wr_en,
	input  logic        cfg_addr,
	input  logic [7:0]  cfg_wdata,
	output int          mismatch_count,
	output int          statuses_due
);
	import cfpp_pkg::*;

	localparam int PRINT_CAP = 40;

	typedef struct packed {
		cfpp_hdr_t hdr;
		cfpp_env_t env;
	} frame_status_t;

	// register copies
	logic [6:0]  cfg_max_len;
	logic [7:0]  cfg_env_type;

	// parser copy
	cfpp_phase_t hunt_phase;
	logic [15:0] crc_run;
	logic [7:0]  frame_kind;
	logic [6:0]  frame_len;
	logic [6:0]  payload_idx;
	logic [7:0]  crc_lo_seen;
	logic [7:0]  kept [DECODE_DEPTH];

	frame_status_t status_q[$];
	int          status_no;

	function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	// Advances the parser copy by one byte; returns 1 when a status is due.
	function automatic bit parse_byte(input logic [7:0] b, output frame_status_t st);
		logic [7:0] limit;
		bit         due;
		st = '0;
		due = 1'b0;
		st.hdr.frame_type = frame_kind;
		st.hdr.payload_length = {1'b0, frame_len};
		case (hunt_phase)
			PH_TYPE: begin
				frame_kind = b;
				crc_run = crc16_update(crc_run, b);
				hunt_phase = PH_LEN;
			end
			PH_LEN: begin
				crc_run = crc16_update(crc_run, b);
				limit = (cfg_max_len > PAYLOAD_LIMIT_DEF) ? 8'(PAYLOAD_LIMIT_DEF)
				                                          : {1'b0, cfg_max_len};
				if (b > limit) begin
					st.hdr.status = ST_TOO_LONG;
					st.hdr.payload_length = b;
					hunt_phase = PH_HEADER;
					due = 1'b1;
				end else begin
					frame_len = b[6:0];
					payload_idx = '0;
					hunt_phase = (b != 0) ? PH_DATA : PH_CRCLO;
				end
			end
			PH_DATA: begin
				if (payload_idx < DECODE_DEPTH)
					kept[payload_idx[3:0]] = b;
				crc_run = crc16_update(crc_run, b);
				payload_idx = payload_idx + 7'd1;
				if (payload_idx >= frame_len)
					hunt_phase = PH_CRCLO;
			end
			PH_CRCLO: begin
				crc_lo_seen = b;
				hunt_phase = PH_CRCHI;
			end
			PH_CRCHI: begin
				if ({b, crc_lo_seen} == crc_run) begin
					hunt_phase = PH_TAIL;
				end else begin
					st.hdr.status = ST_CRC_ERR;
					hunt_phase = PH_HEADER;
					due = 1'b1;
				end
			end
			PH_TAIL: begin
				hunt_phase = PH_HEADER;
				due = 1'b1;
				if (b != TAIL_BYTE) begin
					st.hdr.status = ST_TAIL_ERR;
				end else if (frame_kind == cfg_env_type && frame_len >= ENV_MIN_LEN) begin
					st.hdr.status = ST_ENV;
					st.env.floor_number = kept[0];
					st.env.temperature_tenths = 12'(int'(kept[1]) * TEMP_SCALE + int'(kept[2]));
					st.env.humidity = kept[3];
					if (frame_len >= SEQ_MIN_LEN) begin
						st.env.has_sequence = 1'b1;
						st.env.sequence_number = {kept[5], kept[4]};
						st.env.device_time_ms = {kept[9], kept[8], kept[7], kept[6]};
					end
				end else begin
					st.hdr.status = ST_OTHER;
				end
			end
			default: begin
				// header hunt, also taken for any unused phase code
				hunt_phase = PH_HEADER;
				if (b == HDR_BYTE) begin
					hunt_phase = PH_TYPE;
					crc_run = CRC_INIT;
					foreach (kept[i]) kept[i] = '0;
				end
			end
		endcase
		return due;
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] got,
	                               input logic [31:0] want);
		if (mismatch_count < PRINT_CAP)
			$display("%0t: status item %0d, %s: got 0x%0h, expected 0x%0h",
			         $time, status_no, field, got, want);
		mismatch_count++;
	endtask

	task automatic compare_status();
		frame_status_t want;
		if (status_q.size() == 0) begin
			report_mismatch("item with nothing expected", {28'd0, m_tuser}, '0);
		end else begin
			want = status_q.pop_front();
			if (m_tuser[2:0] != want.hdr.status)
				report_mismatch("status", 32'(m_tuser[2:0]), 32'(want.hdr.status));
			if (m_tdata[7:0] != want.hdr.frame_type)
				report_mismatch("frame_type", 32'(m_tdata[7:0]), 32'(want.hdr.frame_type));
			if (m_tdata[15:8] != want.hdr.payload_length)
				report_mismatch("payload_length", 32'(m_tdata[15:8]),
				                32'(want.hdr.payload_length));
			if (m_tdata[23:16] != want.env.floor_number)
				report_mismatch("floor_number", 32'(m_tdata[23:16]),
				                32'(want.env.floor_number));
			if (m_tdata[35:24] != want.env.temperature_tenths)
				report_mismatch("temperature_tenths", 32'(m_tdata[35:24]),
				                32'(want.env.temperature_tenths));
			if (m_tdata[43:36] != want.env.humidity)
				report_mismatch("humidity", 32'(m_tdata[43:36]), 32'(want.env.humidity));
			if (m_tuser[3] != want.env.has_sequence)
				report_mismatch("has_sequence", 32'(m_tuser[3]), 32'(want.env.has_sequence));
			if (m_tdata[59:44] != want.env.sequence_number)
				report_mismatch("sequence_number", 32'(m_tdata[59:44]),
				                32'(want.env.sequence_number));
			if (m_tdata[91:60] != want.env.device_time_ms)
				report_mismatch("device_time_ms", m_tdata[91:60], want.env.device_time_ms);
		end
		status_no++;
	endtask

	// Sampled mid-cycle: a handshake seen here completes at the next rising edge.
	always @(negedge clk) begin
		frame_status_t st;
		if (!arst_n) begin
			cfg_max_len = MAX_LEN_RST;
			cfg_env_type = ENV_TYPE_RST;
			hunt_phase = PH_HEADER;
			crc_run = CRC_INIT;
			frame_kind = '0;
			frame_len = '0;
			payload_idx = '0;
			crc_lo_seen = '0;
			foreach (kept[i]) kept[i] = '0;
			status_q.delete();
			status_no = 0;
			mismatch_count = 0;
		end else begin
			if (m_tvalid && m_tready)
				compare_status();
			if (s_tvalid && s_tready && parse_byte(s_tdata, st))
				status_q.push_back(st);
			if (cfg_wr_en) begin
				if (cfg_addr == REG_MAX_LEN)
					cfg_max_len = cfg_wdata[6:0];
				else
					cfg_env_type = cfg_wdata;
			end
		end
		statuses_due = status_q.size();
	end

endmodule

>>> tb/sv/crc16_framed_packet_parser_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc16_framed_packet_parser_unit_tb
// Feeds the frame parser directed and random byte streams (good frames, CRC
// and tail errors, over-long lengths, stray bytes) over several register
// settings and idle/stall mixes; the checker predicts and compares statuses.
// ----------------------------------------------------------------------------
module crc16_framed_packet_parser_unit_tb;
	import cfpp_pkg::*;

	localparam int HOLD_OFF_CYCLES = 300;  // long receiver hold-off
	localparam int WATCHDOG_LIMIT  = 2000; // cycles without any item moving
	localparam int DRAIN_CYCLES    = 4;    // input stage and output register plus margin
	localparam int PHASE_BYTES     = 240;  // random bytes per phase

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [95:0] m_tdata;
	logic [3:0]  m_tuser;
	logic        cfg_wr_en;
	logic        cfg_addr;
	logic [7:0]  cfg_wdata;

	int          mismatch_count;
	int          statuses_due;

	// stimulus-side view of the registers, used only to shape frames
	logic [6:0]  max_len_now;
	logic [7:0]  env_type_now;

	int          sender_idle_pct;
	int          receiver_stall_pct;
	int          hold_reqs;
	int          hold_done;
	int unsigned bytes_sent;
	int          quiet_cycles;

	crc16_framed_packet_parser_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	cfpp_status_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_addr       (cfg_addr),
		.cfg_wdata      (cfg_wdata),
		.mismatch_count (mismatch_count),
		.statuses_due   (statuses_due)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Watchdog: any accepted item on either stream restarts the count.
	always @(negedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
					$display("== FAIL ==");
					$finish;
				end
			end
		end
	end

	// Receiver: random stalls per phase; a hold-off request parks m_tready low
	// for a long stretch so the parser backs up and drops s_tready.
	initial begin
		m_tready = 1'b0;
		hold_done = 0;
		forever begin
			@(posedge clk);
			if (hold_reqs != hold_done) begin
				hold_done++;
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
			end else begin
				m_tready <= ($urandom_range(99) >= receiver_stall_pct);
			end
		end
	end

	function automatic logic [15:0] frame_crc_add(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	// One byte item; tready is looked at mid-cycle, the handshake lands on the
	// following rising edge, and the task returns right at that edge.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		bytes_sent++;
	endtask

	// Full frame: header, type, length, payload, CRC (optionally corrupted),
	// tail. Stops after the length byte when the length is over the limit and
	// after the CRC when it was corrupted, as the parser does.
	task automatic send_packet(input logic [7:0] ftype, input logic [7:0] flen,
	                           input bit rand_payload, input logic [7:0] fill,
	                           input logic [15:0] crc_flip, input logic [7:0] tail);
		logic [7:0]  lim;
		logic [7:0]  b;
		logic [15:0] crc;
		int          i;
		lim = (max_len_now > PAYLOAD_LIMIT_DEF) ? 8'(PAYLOAD_LIMIT_DEF) : {1'b0, max_len_now};
		crc = CRC_INIT;
		send_byte(HDR_BYTE);
		send_byte(ftype);
		crc = frame_crc_add(crc, ftype);
		send_byte(flen);
		crc = frame_crc_add(crc, flen);
		if (flen > lim)
			return;
		for (i = 0; i < flen; i++) begin
			b = rand_payload ? 8'($urandom) : fill;
			send_byte(b);
			crc = frame_crc_add(crc, b);
		end
		crc = crc ^ crc_flip;
		send_byte(crc[7:0]);
		send_byte(crc[15:8]);
		if (crc_flip == 16'h0000)
			send_byte(tail);
	endtask

	// Random frame: mostly well formed, with a share of bad CRCs, bad tails and
	// over-long lengths. Half the frames carry the environment type.
	task automatic send_random_frame();
		logic [7:0]  ftype;
		logic [7:0]  flen;
		logic [7:0]  lim;
		logic [7:0]  tail;
		logic [15:0] flip;
		int          r;
		lim = (max_len_now > PAYLOAD_LIMIT_DEF) ? 8'(PAYLOAD_LIMIT_DEF) : {1'b0, max_len_now};
		ftype = $urandom_range(1) ? env_type_now : 8'($urandom_range(255));
		r = $urandom_range(99);
		if (r < 65)
			flen = 8'($urandom_range(12));
		else if (r < 88)
			flen = 8'($urandom_range(lim));
		else
			flen = 8'($urandom_range(255, lim + 1));
		flip = ($urandom_range(99) < 8) ? (16'h0001 << $urandom_range(15)) : 16'h0000;
		r = $urandom_range(99);
		if (r < 3) begin
			// bad tail that looks like a header; must not restart a frame
			tail = HDR_BYTE;
		end else if (r < 8) begin
			do tail = 8'($urandom); while (tail == TAIL_BYTE);
		end else begin
			tail = TAIL_BYTE;
		end
		send_packet(ftype, flen, 1'b1, 8'h00, flip, tail);
	endtask

	// Stray bytes between frames, some of them header bytes that open a
	// frame which the next real frame then breaks up.
	task automatic send_noise();
		int n;
		n = $urandom_range(4, 1);
		repeat (n) send_byte(($urandom_range(3) == 0) ? HDR_BYTE : 8'($urandom));
	endtask

	task automatic run_traffic(input int unsigned n_bytes);
		int unsigned stop_at;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at) begin
			if ($urandom_range(99) < 15)
				send_noise();
			else
				send_random_frame();
		end
	endtask

	// Wait until every predicted status item has come out, then let bytes
	// that make no status finish in the pipeline.
	task automatic drain_statuses();
		s_tvalid <= 1'b0;
		while (statuses_due != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Both registers back to back; bit 7 of the length write is random and
	// must be ignored.
	task automatic program_regs(input logic [6:0] max_len, input logic [7:0] env_type);
		cfg_wr_en <= 1'b1;
		cfg_addr <= REG_MAX_LEN;
		cfg_wdata <= {1'($urandom_range(1)), max_len};
		@(posedge clk);
		cfg_addr <= REG_ENV_TYPE;
		cfg_wdata <= env_type;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		max_len_now = max_len;
		env_type_now = env_type;
	endtask

	task automatic set_idling(input int sender_pct, input int receiver_pct);
		sender_idle_pct = sender_pct;
		receiver_stall_pct = receiver_pct;
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		cfg_wr_en = 1'b0;
		cfg_addr = REG_MAX_LEN;
		cfg_wdata = 8'h00;
		hold_reqs = 0;
		bytes_sent = 0;
		quiet_cycles = 0;
		max_len_now = MAX_LEN_RST;
		env_type_now = ENV_TYPE_RST;
		set_idling(0, 0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset register values, no idling.
		send_byte(8'h00);                                      // stray byte, ignored
		send_packet(ENV_TYPE_RST, 8'd4, 1'b0, 8'hFF, 16'h0000, TAIL_BYTE); // env, max temp
		send_packet(8'h00, 8'd0, 1'b0, 8'h00, 16'h0000, HDR_BYTE); // zero length, bad tail
		send_packet(8'hFF, 8'd0, 1'b0, 8'h00, 16'h8000, TAIL_BYTE); // CRC mismatch
		send_packet(8'h7E, 8'hFF, 1'b0, 8'h00, 16'h0000, TAIL_BYTE); // length too big

		// Random with a long receiver hold-off while the sender keeps pushing.
		hold_reqs++;
		run_traffic(PHASE_BYTES);
		drain_statuses();

		// Largest length register (capped by the block), top env type.
		program_regs(7'd127, 8'hFF);
		set_idling(72, 0);
		run_traffic(PHASE_BYTES);
		drain_statuses();

		// Zero length limit: every frame with payload is dropped.
		program_regs(7'd0, 8'h00);
		set_idling(0, 72);
		run_traffic(PHASE_BYTES);
		drain_statuses();

		// Limit right at the sequence threshold.
		program_regs(7'd10, ENV_TYPE_RST);
		set_idling(7, 7);
		run_traffic(PHASE_BYTES);
		drain_statuses();

		program_regs(7'($urandom_range(127)), 8'($urandom_range(255)));
		set_idling(0, 0);
		run_traffic(PHASE_BYTES);
		drain_statuses();

		if (mismatch_count == 0 && statuses_due == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
